FILE: rtl/mlk_pkg.sv
// Shared types, constants and the Morse symbol table for the letter keyer.
package mlk_pkg;

    localparam int MAX_SYMBOLS = 5;
    localparam int TABLE_COLS  = 8;
    localparam int NUM_LETTERS = 26;

    localparam logic [1:0]  SYM_NONE         = 2'd0;
    localparam logic [1:0]  SYM_DOT          = 2'd1;
    localparam logic [1:0]  SYM_DASH         = 2'd3;
    localparam logic [15:0] DOT_TICKS_RESET  = 16'd300;
    localparam logic [7:0]  FIRST_LETTER     = 8'd97;
    localparam logic [7:0]  LAST_LETTER      = 8'd122;
    localparam logic [2:0]  LETTER_GAP_UNITS = 3'd3;
    localparam logic [1:0]  QUEUE_DEPTH      = 2'd2;

    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_LOAD = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_ON     = 2'd1,
        PH_SYMGAP = 2'd2,
        PH_LETGAP = 2'd3
    } t_phase;

    typedef struct packed {
        logic       func;
        logic [7:0] letter;
    } t_item;

    typedef struct packed {
        logic led_on;
        logic busy_res;
        logic accepted;
        logic rejected;
        logic letter_done;
    } t_result;

    // Classified command handed from the front end to the back end.
    typedef struct packed {
        logic       is_load;
        logic       in_range;
        logic [4:0] index;
    } t_cmd;

    typedef logic [TABLE_COLS-1:0][1:0] t_row;

    function automatic logic [1:0] symbol_at(logic [4:0] row, logic [3:0] pos);
        t_row r;
        r = '0;
        case (row)
            5'd0:  begin r[0] = SYM_DOT;  r[1] = SYM_DASH; end
            5'd1:  begin r[0] = SYM_DASH; r[1] = SYM_DOT;  r[2] = SYM_DOT;  r[3] = SYM_DOT;  end
            5'd2:  begin r[0] = SYM_DASH; r[1] = SYM_DOT;  r[2] = SYM_DASH; r[3] = SYM_DOT;  end
            5'd3:  begin r[0] = SYM_DASH; r[1] = SYM_DOT;  r[2] = SYM_DOT;  end
            5'd4:  begin r[0] = SYM_DOT;  end
            5'd5:  begin r[0] = SYM_DOT;  r[1] = SYM_DOT;  r[2] = SYM_DASH; r[3] = SYM_DOT;  end
            5'd6:  begin r[0] = SYM_DASH; r[1] = SYM_DASH; r[2] = SYM_DOT;  end
            5'd7:  begin r[0] = SYM_DOT;  r[1] = SYM_DOT;  r[2] = SYM_DOT;  r[3] = SYM_DOT;  end
            5'd8:  begin r[0] = SYM_DOT;  r[1] = SYM_DOT;  end
            5'd9:  begin r[0] = SYM_DOT;  r[1] = SYM_DASH; r[2] = SYM_DASH; r[3] = SYM_DASH; end
            5'd10: begin r[0] = SYM_DASH; r[1] = SYM_DOT;  r[2] = SYM_DASH; end
            5'd11: begin r[0] = SYM_DOT;  r[1] = SYM_DASH; r[2] = SYM_DOT;  r[3] = SYM_DOT;  end
            5'd12: begin r[0] = SYM_DASH; r[1] = SYM_DASH; end
            5'd13: begin r[0] = SYM_DASH; r[1] = SYM_DOT;  end
            5'd14: begin r[0] = SYM_DASH; r[1] = SYM_DASH; r[2] = SYM_DASH; end
            5'd15: begin r[0] = SYM_DOT;  r[1] = SYM_DASH; r[2] = SYM_DASH; r[3] = SYM_DOT;  end
            5'd16: begin r[0] = SYM_DASH; r[1] = SYM_DASH; r[2] = SYM_DOT;  r[3] = SYM_DASH; end
            5'd17: begin r[0] = SYM_DOT;  r[1] = SYM_DASH; r[2] = SYM_DOT;  end
            5'd18: begin r[0] = SYM_DOT;  r[1] = SYM_DOT;  r[2] = SYM_DOT;  end
            5'd19: begin r[0] = SYM_DASH; end
            5'd20: begin r[0] = SYM_DOT;  r[1] = SYM_DOT;  r[2] = SYM_DASH; end
            5'd21: begin r[0] = SYM_DOT;  r[1] = SYM_DOT;  r[2] = SYM_DOT;  r[3] = SYM_DASH; end
            5'd22: begin r[0] = SYM_DOT;  r[1] = SYM_DASH; r[2] = SYM_DASH; end
            5'd23: begin r[0] = SYM_DASH; r[1] = SYM_DOT;  r[2] = SYM_DOT;  r[3] = SYM_DASH; end
            5'd24: begin r[0] = SYM_DASH; r[1] = SYM_DOT;  r[2] = SYM_DASH; r[3] = SYM_DASH; end
            5'd25: begin r[0] = SYM_DASH; r[1] = SYM_DASH; r[2] = SYM_DOT;  r[3] = SYM_DOT;  end
            default: r = '0;
        endcase
        if (pos >= 4'(MAX_SYMBOLS) || pos >= 4'(TABLE_COLS)) begin
            return SYM_NONE;
        end
        return r[pos[2:0]];
    endfunction

endpackage

FILE: rtl/mlk_front.sv
// Front end: takes input transactions, classifies them and queues the commands.
module mlk_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  mlk_pkg::t_item i_item,
    output logic          o_cmd_valid,
    output mlk_pkg::t_cmd o_cmd,
    input  logic          i_cmd_take
);
    import mlk_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    t_cmd       w_cmd;
    logic       w_wr;
    logic       w_rd;

    always_comb begin
        w_cmd.is_load  = (i_item.func == FUNC_LOAD);
        w_cmd.in_range = (i_item.letter inside {[FIRST_LETTER:LAST_LETTER]});
        w_cmd.index    = 5'(i_item.letter - FIRST_LETTER);
    end

    assign full        = (r_cnt == QUEUE_DEPTH);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_mem[r_rp];
    assign w_wr        = push && !full;
    assign w_rd        = i_cmd_take && o_cmd_valid;

    always_comb begin
        n_cnt = r_cnt;
        if (w_wr && !w_rd) begin
            n_cnt = r_cnt + 2'd1;
        end else if (w_rd && !w_wr) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (w_wr) begin
                r_wp <= ~r_wp;
            end
            if (w_rd) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= w_cmd;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QUEUE_DEPTH) else $error("front queue count overflow");

    a_no_take_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 && !w_wr) |=> (r_cnt == 2'd0))
        else $error("front queue count moved without a write");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 || r_cnt == QUEUE_DEPTH) |-> (r_wp == r_rp))
        else $error("front queue pointers disagree with count");

endmodule

FILE: rtl/mlk_back.sv
// Back end: keyer state machine, unit timing and the result queue.
module mlk_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_wr_en,
    input  logic [15:0]     i_cfg_wr_data,
    input  logic            i_cmd_valid,
    input  mlk_pkg::t_cmd   i_cmd,
    output logic            o_cmd_take,
    output logic            empty,
    input  logic            pop,
    output mlk_pkg::t_result o_result
);
    import mlk_pkg::*;

    t_phase      r_phase;
    t_phase      n_phase;
    logic [4:0]  r_letter_index;
    logic [4:0]  n_letter_index;
    logic [2:0]  r_symbol_pos;
    logic [2:0]  n_symbol_pos;
    logic [2:0]  r_units_left;
    logic [2:0]  n_units_left;
    logic [15:0] r_ticks_left;
    logic [15:0] n_ticks_left;
    logic [15:0] r_dot_ticks;

    t_result     r_out_mem [2];
    logic        r_out_wp;
    logic        r_out_rp;
    logic [1:0]  r_out_cnt;
    logic [1:0]  n_out_cnt;

    t_result     w_res;
    logic        w_exec;
    logic        w_pop;
    logic [15:0] w_unit_len;
    logic [3:0]  w_next_pos;
    logic [1:0]  w_next_sym;
    logic [1:0]  w_first_sym;

    assign w_pop      = pop && !empty;
    assign o_cmd_take = (r_out_cnt != QUEUE_DEPTH) || w_pop;
    assign w_exec     = i_cmd_valid && o_cmd_take;
    assign w_unit_len = (r_dot_ticks == 16'd0) ? 16'd1 : r_dot_ticks;
    assign w_next_pos = {1'b0, r_symbol_pos} + 4'd1;
    assign w_next_sym = symbol_at(r_letter_index, w_next_pos);
    assign w_first_sym = symbol_at(i_cmd.index, 4'd0);

    always_comb begin
        n_phase        = r_phase;
        n_letter_index = r_letter_index;
        n_symbol_pos   = r_symbol_pos;
        n_units_left   = r_units_left;
        n_ticks_left   = r_ticks_left;
        w_res          = '0;
        if (i_cmd.is_load) begin
            if (r_phase != PH_IDLE || !i_cmd.in_range) begin
                w_res.rejected = 1'b1;
            end else begin
                n_letter_index = i_cmd.index;
                n_symbol_pos   = 3'd0;
                n_phase        = PH_ON;
                n_units_left   = {1'b0, w_first_sym};
                n_ticks_left   = w_unit_len;
                w_res.accepted = 1'b1;
            end
        end else if (r_phase != PH_IDLE) begin
            if (r_ticks_left > 16'd1) begin
                n_ticks_left = r_ticks_left - 16'd1;
            end else begin
                n_ticks_left = w_unit_len;
                if (r_units_left > 3'd1) begin
                    n_units_left = r_units_left - 3'd1;
                end else begin
                    n_units_left = 3'd0;
                    case (r_phase)
                        PH_ON: begin
                            n_phase      = PH_SYMGAP;
                            n_units_left = 3'd1;
                        end
                        PH_SYMGAP: begin
                            if (w_next_sym != SYM_NONE) begin
                                n_symbol_pos = w_next_pos[2:0];
                                n_phase      = PH_ON;
                                n_units_left = {1'b0, w_next_sym};
                            end else begin
                                n_phase      = PH_LETGAP;
                                n_units_left = LETTER_GAP_UNITS;
                            end
                        end
                        PH_LETGAP: begin
                            n_phase           = PH_IDLE;
                            n_ticks_left      = 16'd0;
                            n_symbol_pos      = 3'd0;
                            w_res.letter_done = 1'b1;
                        end
                        default: n_phase = r_phase;
                    endcase
                end
            end
        end
        w_res.led_on   = (n_phase == PH_ON);
        w_res.busy_res = (n_phase != PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_letter_index <= 5'd0;
            r_symbol_pos   <= 3'd0;
            r_units_left   <= 3'd0;
            r_ticks_left   <= 16'd0;
        end else if (w_exec) begin
            r_phase        <= n_phase;
            r_letter_index <= n_letter_index;
            r_symbol_pos   <= n_symbol_pos;
            r_units_left   <= n_units_left;
            r_ticks_left   <= n_ticks_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot_ticks <= DOT_TICKS_RESET;
        end else if (i_cfg_wr_en) begin
            r_dot_ticks <= i_cfg_wr_data;
        end
    end

    // Result queue.
    assign empty    = (r_out_cnt == 2'd0);
    assign o_result = r_out_mem[r_out_rp];

    always_comb begin
        n_out_cnt = r_out_cnt;
        if (w_exec && !w_pop) begin
            n_out_cnt = r_out_cnt + 2'd1;
        end else if (w_pop && !w_exec) begin
            n_out_cnt = r_out_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_wp  <= 1'b0;
            r_out_rp  <= 1'b0;
            r_out_cnt <= 2'd0;
        end else begin
            r_out_cnt <= n_out_cnt;
            if (w_exec) begin
                r_out_wp <= ~r_out_wp;
            end
            if (w_pop) begin
                r_out_rp <= ~r_out_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exec) begin
            r_out_mem[r_out_wp] <= w_res;
        end
    end

    a_idle_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_units_left == 3'd0))
        else $error("idle keyer holds a unit count");

    a_busy_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_IDLE) |-> (r_units_left != 3'd0 && r_ticks_left != 16'd0))
        else $error("sending keyer ran out of units or ticks");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_exec && w_res.letter_done) |=> (r_phase == PH_IDLE))
        else $error("letter end did not return to idle");

    a_acc_rej: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_exec |-> !(w_res.accepted && w_res.rejected))
        else $error("load both accepted and rejected");

endmodule

FILE: rtl/morse_letter_keyer.sv
// Top level of the tick-driven Morse letter keyer.
// Path: an item is registered in the front queue, then executed by the back end, whose result
// is registered in the result queue, from which it is popped.
// Throughput: one item per cycle unless the result queue is full and not popped.
// Each of the two internal queues holds two entries, so either side may stall alone.
// Reset (synchronous, active low) empties both queues, returns the keyer to idle
// and sets the unit length to 300 ticks.
module morse_letter_keyer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    output logic             full,
    input  mlk_pkg::t_item   i_item,
    output logic             empty,
    input  logic             pop,
    output mlk_pkg::t_result o_result,
    input  logic             i_cfg_wr_en,
    input  logic [15:0]      i_cfg_wr_data
);
    import mlk_pkg::*;

    // The front end decodes each transaction into a command: whether it is a
    // load, whether the letter lies in a to z, and its row in the code table.
    logic w_cmd_valid;
    logic w_cmd_take;
    t_cmd w_cmd;

    mlk_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_take  (w_cmd_take)
    );

    // The back end runs one command per cycle against the keyer state and
    // writes one result per command into its result queue. It stops taking
    // commands only when that queue is full and nothing is popped.
    mlk_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd_valid   (w_cmd_valid),
        .i_cmd         (w_cmd),
        .o_cmd_take    (w_cmd_take),
        .empty         (empty),
        .pop           (pop),
        .o_result      (o_result)
    );

endmodule
